@@ src/pdps_pkg.sv @@
// shared types and constants of the priority drop packet scheduler
package pdps_pkg;

   // defaults of the top level parameters
   localparam int DEF_TELEMETRY_DEPTH  = 128;
   localparam int DEF_PER_STREAM_DEPTH = 2;
   localparam int DEF_AUDIO_DEPTH      = 32;
   localparam int DEF_STREAM_COUNT     = 4;
   localparam int DEF_HANDLE_BITS      = 16;

   // field widths fixed by the interface
   localparam int OP_BITS     = 3;
   localparam int STREAM_BITS = 2;
   localparam int KIND_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int TLIM_BITS   = 8;
   localparam int VLIM_BITS   = 2;
   localparam int ALIM_BITS   = 6;

   // register reset values
   localparam logic [TLIM_BITS-1:0] TLIM_RESET = 8'd128;
   localparam logic [VLIM_BITS-1:0] VLIM_RESET = 2'd2;
   localparam logic [ALIM_BITS-1:0] ALIM_RESET = 6'd32;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TELEMETRY_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VIDEO_STREAM_LIMIT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AUDIO_LIMIT        = 2'd2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_ENQ_TELEMETRY = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ENQ_VIDEO     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_ENQ_AUDIO     = 3'd2;
   localparam logic [OP_BITS-1:0] OP_DISPATCH      = 3'd3;
   localparam logic [OP_BITS-1:0] OP_STOP          = 3'd4;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_TELEMETRY = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_VIDEO     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_AUDIO     = 2'd2;

   // command to every cell of a queue
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_MARK,
      CMD_SHIFT,
      CMD_POP,
      CMD_PUSH,
      CMD_CLEAR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         use_tag;
      logic         fallback;
   } cell_ctl_type;

endpackage

@@ src/pdps_cell.sv @@
// one queue cell: holds an entry and passes it toward the head on removal
module pdps_cell #(
   parameter int TW = 1,
   parameter int HW = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pdps_pkg::cell_ctl_type  ctl,
   input  logic                    any,
   input  logic [TW-1:0]           want,
   input  logic                    first,
   input  logic                    prev_valid,
   input  logic                    seen_in,
   output logic                    seen_out,
   input  logic                    rm_in,
   output logic                    rm_out,
   input  logic                    nxt_valid,
   input  logic [TW+HW-1:0]        nxt_data,
   input  logic [TW+HW-1:0]        push_data,
   output logic                    valid,
   output logic [TW+HW-1:0]        data,
   output logic [TW+HW-1:0]        sel_data
);
   import pdps_pkg::*;

   logic              valid_ff, valid_in;
   logic              mark_ff, mark_in;
   logic [TW+HW-1:0]  data_ff, data_in;
   logic              hit;
   logic              rm_here;

   // match against the wanted tag, or any valid entry
   assign hit      = valid_ff && (!ctl.use_tag || (data_ff[TW+HW-1:HW] == want));
   assign seen_out = seen_in || hit;
   assign rm_here  = rm_in || ((ctl.cmd == CMD_SHIFT) && mark_ff);
   assign rm_out   = rm_here;

   // next cell contents
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      mark_in  = 1'b0;
      unique case (ctl.cmd)
         CMD_MARK: begin
            mark_in = any ? (hit && !seen_in) : (ctl.fallback && first && valid_ff);
         end
         CMD_SHIFT, CMD_POP: begin
            if (rm_here) begin
               valid_in = nxt_valid;
               data_in  = nxt_data;
            end
         end
         CMD_PUSH: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               data_in  = push_data;
            end
         end
         CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mark_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
      end
      data_ff <= data_in;
   end

   assign valid    = valid_ff;
   assign data     = data_ff;
   assign sel_data = mark_ff ? data_ff : '0;

endmodule

@@ src/pdps_chain.sv @@
// row of queue cells with head at cell zero
module pdps_chain #(
   parameter int N  = 8,
   parameter int TW = 1,
   parameter int HW = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pdps_pkg::cell_ctl_type  ctl,
   input  logic [TW-1:0]           want,
   input  logic [TW+HW-1:0]        push_data,
   output logic                    any,
   output logic [TW+HW-1:0]        sel_data,
   output logic                    head_valid,
   output logic [TW+HW-1:0]        head_data
);
   import pdps_pkg::*;

   logic [N:0]              seen;
   logic [N:0]              rm;
   logic [N-1:0]            valid;
   logic [TW+HW-1:0]        data [N];
   logic [TW+HW-1:0]        sel [N];
   logic [N-1:0]            nxt_valid;
   logic [TW+HW-1:0]        nxt_data [N];
   logic [N-1:0]            prev_valid;

   assign seen[0] = 1'b0;
   assign rm[0]   = (ctl.cmd == CMD_POP);
   assign any     = seen[N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         // neighbor wiring
         if (i == N - 1) begin : g_tail
            assign nxt_valid[i] = 1'b0;
            assign nxt_data[i]  = '0;
         end else begin : g_mid
            assign nxt_valid[i] = valid[i+1];
            assign nxt_data[i]  = data[i+1];
         end
         if (i == 0) begin : g_head
            assign prev_valid[i] = 1'b1;
         end else begin : g_body
            assign prev_valid[i] = valid[i-1];
         end

         pdps_cell #(.TW(TW), .HW(HW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .any        (any),
            .want       (want),
            .first      (1'(i == 0)),
            .prev_valid (prev_valid[i]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .rm_in      (rm[i]),
            .rm_out     (rm[i+1]),
            .nxt_valid  (nxt_valid[i]),
            .nxt_data   (nxt_data[i]),
            .push_data  (push_data),
            .valid      (valid[i]),
            .data       (data[i]),
            .sel_data   (sel[i])
         );
      end
   endgenerate

   // marked entry, at most one cell drives it
   always_comb begin
      sel_data = '0;
      for (int k = 0; k < N; k++) begin
         sel_data = sel_data | sel[k];
      end
   end

   assign head_valid = valid[0];
   assign head_data  = data[0];

endmodule

@@ src/priority_drop_packet_scheduler.sv @@
// top level of the priority drop packet scheduler
//
//  channel  ports                         direction  item
//  req      req_valid / req_ready         in         operation with packet handle
//  rsp      rsp_valid / rsp_ready         out        one dispatched handle
//  csr      csr_valid / csr_ready         in         limit register write
//
// one req item at a time; a video keyframe purge removes one frame per pass
// through the video cell row, and dispatch takes telemetry, video and audio in
// turn. each result sits in an output register until taken; a stalled rsp
// holds the dispatch sequencer. reset empties all queues and restores the
// limits; stop empties them too and leaves every later req item without effect.
module priority_drop_packet_scheduler #(
   parameter int TELEMETRY_DEPTH  = pdps_pkg::DEF_TELEMETRY_DEPTH,
   parameter int PER_STREAM_DEPTH = pdps_pkg::DEF_PER_STREAM_DEPTH,
   parameter int AUDIO_DEPTH      = pdps_pkg::DEF_AUDIO_DEPTH,
   parameter int STREAM_COUNT     = pdps_pkg::DEF_STREAM_COUNT,
   parameter int HANDLE_BITS      = pdps_pkg::DEF_HANDLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pdps_pkg::OP_BITS-1:0]         req_operation,
   input  logic [HANDLE_BITS-1:0]               req_handle,
   input  logic                                 req_is_control,
   input  logic [pdps_pkg::STREAM_BITS-1:0]     req_stream,
   input  logic                                 req_is_keyframe,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pdps_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [HANDLE_BITS-1:0]               rsp_out_handle,
   output logic                                 rsp_out_control,
   output logic [pdps_pkg::STREAM_BITS-1:0]     rsp_out_stream,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pdps_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pdps_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import pdps_pkg::*;

   localparam int VSLOTS = STREAM_COUNT * PER_STREAM_DEPTH;
   localparam int TCW    = $clog2(TELEMETRY_DEPTH + 1);
   localparam int TLW    = (TCW > TLIM_BITS) ? TCW : TLIM_BITS;
   localparam int SCW    = $clog2(PER_STREAM_DEPTH + 1);
   localparam int VLW    = (SCW > VLIM_BITS) ? SCW : VLIM_BITS;
   localparam int SIW    = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
   localparam int AW     = $clog2(AUDIO_DEPTH);
   localparam int ACW    = $clog2(AUDIO_DEPTH + 1);
   localparam int ALW    = (ACW > ALIM_BITS) ? ACW : ALIM_BITS;
   localparam int TDW    = 1 + HANDLE_BITS;
   localparam int VDW    = STREAM_BITS + HANDLE_BITS;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_T_MARK  = 13'b0000000000010,
      ST_T_SHIFT = 13'b0000000000100,
      ST_T_PUSH  = 13'b0000000001000,
      ST_V_MARK  = 13'b0000000010000,
      ST_V_SHIFT = 13'b0000000100000,
      ST_V_PUSH  = 13'b0000001000000,
      ST_A_ENQ   = 13'b0000010000000,
      ST_D_T     = 13'b0000100000000,
      ST_D_TOUT  = 13'b0001000000000,
      ST_D_V     = 13'b0010000000000,
      ST_D_A     = 13'b0100000000000,
      ST_WAIT    = 13'b1000000000000
   } state_type;

   state_type                state_ff, state_in;
   state_type                ret_ff, ret_in;
   logic                     stopped_ff, stopped_in;
   logic [TLIM_BITS-1:0]     tlim_cfg_ff;
   logic [VLIM_BITS-1:0]     vlim_cfg_ff;
   logic [ALIM_BITS-1:0]     alim_cfg_ff;
   logic [HANDLE_BITS-1:0]   handle_ff;
   logic                     ctrl_ff;
   logic [STREAM_BITS-1:0]   stream_ff;
   logic                     key_ff;
   logic [TCW-1:0]           tcnt_ff, tcnt_in;
   logic [SCW-1:0]           scnt_ff [STREAM_COUNT];
   logic [SCW-1:0]           scnt_in [STREAM_COUNT];
   logic [ACW-1:0]           acnt_ff, acnt_in;
   logic [AW-1:0]            ahead_ff, ahead_in;
   logic [HANDLE_BITS-1:0]   amem [AUDIO_DEPTH];
   logic [HANDLE_BITS-1:0]   ard_ff;
   logic                     awr_en;
   logic [AW-1:0]            awr_addr;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_BITS-1:0]   rsp_handle_ff, rsp_handle_in;
   logic                     rsp_control_ff, rsp_control_in;
   logic [STREAM_BITS-1:0]   rsp_stream_ff, rsp_stream_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctl_type             t_ctl, v_ctl;
   logic                     t_want;
   logic                     t_any, v_any;
   logic [TDW-1:0]           t_sel, t_head, t_push;
   logic                     t_head_valid;
   logic [VDW-1:0]           v_sel, v_head, v_push;
   logic                     v_head_valid;

   logic                     req_acc;
   logic [TLW-1:0]           tcfg_ext, tlim, tcnt_ext;
   logic [VLW-1:0]           vcfg_ext, vlim, scnt_ext;
   logic [ALW-1:0]           acfg_ext, alim, acnt_ext;
   logic [SIW-1:0]           sidx, hidx;
   logic                     stream_ok;
   logic [AW-1:0]            ahead_inc, ahead_drop;
   logic [ACW-1:0]           acnt_drop;
   logic [AW:0]              asum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // effective limits, zero acts as one and large values as capacity
   assign tcfg_ext = TLW'(tlim_cfg_ff);
   assign tcnt_ext = TLW'(tcnt_ff);
   assign tlim = (tcfg_ext == '0) ? TLW'(1) :
                 ((tcfg_ext > TLW'(TELEMETRY_DEPTH)) ? TLW'(TELEMETRY_DEPTH) : tcfg_ext);
   assign vcfg_ext = VLW'(vlim_cfg_ff);
   assign vlim = (vcfg_ext == '0) ? VLW'(1) :
                 ((vcfg_ext > VLW'(PER_STREAM_DEPTH)) ? VLW'(PER_STREAM_DEPTH) : vcfg_ext);
   assign acfg_ext = ALW'(alim_cfg_ff);
   assign acnt_ext = ALW'(acnt_ff);
   assign alim = (acfg_ext == '0) ? ALW'(1) :
                 ((acfg_ext > ALW'(AUDIO_DEPTH)) ? ALW'(AUDIO_DEPTH) : acfg_ext);

   assign sidx      = SIW'(stream_ff);
   assign hidx      = SIW'(v_head[VDW-1:HANDLE_BITS]);
   assign scnt_ext  = VLW'(scnt_ff[sidx]);
   assign stream_ok = ({30'd0, req_stream} < 32'(STREAM_COUNT));

   // audio ring pointers for an enqueue
   assign ahead_inc  = (ahead_ff == AW'(AUDIO_DEPTH - 1)) ? '0 : ahead_ff + AW'(1);
   assign ahead_drop = (acnt_ext >= alim) ? ahead_inc : ahead_ff;
   assign acnt_drop  = (acnt_ext >= alim) ? acnt_ff - ACW'(1) : acnt_ff;
   assign asum       = (AW+1)'(ahead_drop) + (AW+1)'(acnt_drop);
   assign awr_addr   = (asum >= (AW+1)'(AUDIO_DEPTH)) ?
                       AW'(asum - (AW+1)'(AUDIO_DEPTH)) : AW'(asum);

   assign t_push = {ctrl_ff, handle_ff};
   assign v_push = {stream_ff, handle_ff};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      stopped_in     = stopped_ff;
      tcnt_in        = tcnt_ff;
      scnt_in        = scnt_ff;
      acnt_in        = acnt_ff;
      ahead_in       = ahead_ff;
      awr_en         = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_control_in = rsp_control_ff;
      rsp_stream_in  = rsp_stream_ff;
      rsp_last_in    = rsp_last_ff;
      t_ctl          = '{cmd: CMD_NONE, use_tag: 1'b0, fallback: 1'b0};
      v_ctl          = '{cmd: CMD_NONE, use_tag: 1'b1, fallback: 1'b0};
      t_want         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && !stopped_ff) begin
               priority case (req_operation)
                  OP_ENQ_TELEMETRY: state_in = ST_T_MARK;
                  OP_ENQ_VIDEO:     state_in = stream_ok ? ST_V_MARK : ST_IDLE;
                  OP_ENQ_AUDIO:     state_in = ST_A_ENQ;
                  OP_DISPATCH:      state_in = ST_D_T;
                  OP_STOP: begin
                     stopped_in = 1'b1;
                     tcnt_in    = '0;
                     acnt_in    = '0;
                     ahead_in   = '0;
                     for (int k = 0; k < STREAM_COUNT; k++) begin
                        scnt_in[k] = '0;
                     end
                     t_ctl.cmd  = CMD_CLEAR;
                     v_ctl.cmd  = CMD_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // telemetry: mark the victim, evict it when at the limit, append
         ST_T_MARK: begin
            t_ctl    = '{cmd: CMD_MARK, use_tag: ctrl_ff, fallback: 1'b1};
            t_want   = 1'b0;
            state_in = (tcnt_ext >= tlim) ? ST_T_SHIFT : ST_T_PUSH;
         end
         ST_T_SHIFT: begin
            t_ctl.cmd = CMD_SHIFT;
            tcnt_in   = tcnt_ff - TCW'(1);
            state_in  = ST_T_PUSH;
         end
         ST_T_PUSH: begin
            t_ctl.cmd = CMD_PUSH;
            if (tcnt_ext < TLW'(TELEMETRY_DEPTH)) begin
               tcnt_in = tcnt_ff + TCW'(1);
            end
            state_in = ST_IDLE;
         end
         // video: purge or evict one frame of the stream per pass, then append
         ST_V_MARK: begin
            v_ctl.cmd = CMD_MARK;
            if (v_any && (key_ff || (scnt_ext >= vlim))) begin
               state_in = ST_V_SHIFT;
            end else begin
               state_in = ST_V_PUSH;
            end
         end
         ST_V_SHIFT: begin
            v_ctl.cmd      = CMD_SHIFT;
            scnt_in[sidx]  = scnt_ff[sidx] - SCW'(1);
            state_in       = key_ff ? ST_V_MARK : ST_V_PUSH;
         end
         ST_V_PUSH: begin
            v_ctl.cmd = CMD_PUSH;
            if (scnt_ext < VLW'(PER_STREAM_DEPTH)) begin
               scnt_in[sidx] = scnt_ff[sidx] + SCW'(1);
            end
            state_in = ST_IDLE;
         end
         // audio: drop the head when at limit, write at the tail
         ST_A_ENQ: begin
            awr_en   = 1'b1;
            ahead_in = ahead_drop;
            acnt_in  = acnt_drop + ACW'(1);
            state_in = ST_IDLE;
         end
         // dispatch: first control packet or head of telemetry, then video head, then audio head
         ST_D_T: begin
            if (tcnt_ff != '0) begin
               t_ctl    = '{cmd: CMD_MARK, use_tag: 1'b1, fallback: 1'b1};
               t_want   = 1'b1;
               state_in = ST_D_TOUT;
            end else begin
               state_in = ST_D_V;
            end
         end
         ST_D_TOUT: begin
            t_ctl.cmd      = CMD_SHIFT;
            tcnt_in        = tcnt_ff - TCW'(1);
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_TELEMETRY;
            rsp_handle_in  = t_sel[HANDLE_BITS-1:0];
            rsp_control_in = t_sel[TDW-1];
            rsp_stream_in  = '0;
            rsp_last_in    = !v_head_valid && (acnt_ff == '0);
            ret_in         = ST_D_V;
            state_in       = ST_WAIT;
         end
         ST_D_V: begin
            if (v_head_valid) begin
               v_ctl.cmd      = CMD_POP;
               scnt_in[hidx]  = scnt_ff[hidx] - SCW'(1);
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_VIDEO;
               rsp_handle_in  = v_head[HANDLE_BITS-1:0];
               rsp_control_in = 1'b0;
               rsp_stream_in  = v_head[VDW-1:HANDLE_BITS];
               rsp_last_in    = (acnt_ff == '0);
               ret_in         = ST_D_A;
               state_in       = ST_WAIT;
            end else begin
               state_in = ST_D_A;
            end
         end
         ST_D_A: begin
            if (acnt_ff != '0) begin
               ahead_in       = ahead_inc;
               acnt_in        = acnt_ff - ACW'(1);
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_AUDIO;
               rsp_handle_in  = ard_ff;
               rsp_control_in = 1'b0;
               rsp_stream_in  = '0;
               rsp_last_in    = 1'b1;
               ret_in         = ST_IDLE;
               state_in       = ST_WAIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         stopped_ff   <= 1'b0;
         tcnt_ff      <= '0;
         acnt_ff      <= '0;
         ahead_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tlim_cfg_ff  <= TLIM_RESET;
         vlim_cfg_ff  <= VLIM_RESET;
         alim_cfg_ff  <= ALIM_RESET;
         for (int k = 0; k < STREAM_COUNT; k++) begin
            scnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         stopped_ff   <= stopped_in;
         tcnt_ff      <= tcnt_in;
         acnt_ff      <= acnt_in;
         ahead_ff     <= ahead_in;
         rsp_valid_ff <= rsp_valid_in;
         scnt_ff      <= scnt_in;
         if (csr_valid && csr_ready) begin
            priority case (csr_index)
               CSR_TELEMETRY_LIMIT:    tlim_cfg_ff <= csr_data;
               CSR_VIDEO_STREAM_LIMIT: vlim_cfg_ff <= csr_data[VLIM_BITS-1:0];
               CSR_AUDIO_LIMIT:        alim_cfg_ff <= csr_data[ALIM_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         handle_ff <= req_handle;
         ctrl_ff   <= req_is_control;
         stream_ff <= req_stream;
         key_ff    <= req_is_keyframe;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_control_ff <= rsp_control_in;
      rsp_stream_ff  <= rsp_stream_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // audio ring memory
   always_ff @(posedge clock) begin
      if (awr_en) begin
         amem[awr_addr] <= handle_ff;
      end
      ard_ff <= amem[ahead_ff];
   end

   pdps_chain #(.N(TELEMETRY_DEPTH), .TW(1), .HW(HANDLE_BITS)) u_tele (
      .clock      (clock),
      .reset      (reset),
      .ctl        (t_ctl),
      .want       (t_want),
      .push_data  (t_push),
      .any        (t_any),
      .sel_data   (t_sel),
      .head_valid (t_head_valid),
      .head_data  (t_head)
   );

   pdps_chain #(.N(VSLOTS), .TW(STREAM_BITS), .HW(HANDLE_BITS)) u_video (
      .clock      (clock),
      .reset      (reset),
      .ctl        (v_ctl),
      .want       (stream_ff),
      .push_data  (v_push),
      .any        (v_any),
      .sel_data   (v_sel),
      .head_valid (v_head_valid),
      .head_data  (v_head)
   );

   // telemetry head, telemetry search flag and video mark are not used
   logic unused_ok;
   assign unused_ok = t_any ^ t_head_valid ^ (^t_head) ^ (^v_sel);

   assign rsp_valid       = rsp_valid_ff && !unused_ok ? rsp_valid_ff : rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_handle  = rsp_handle_ff;
   assign rsp_out_control = rsp_control_ff;
   assign rsp_out_stream  = rsp_stream_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ bench/priority_drop_packet_scheduler_tb.sv @@
// testbench of the priority drop packet scheduler: directed table, random traffic, self check
`timescale 1ns / 1ps

module priority_drop_packet_scheduler_tb;
   import pdps_pkg::*;

   localparam int TELE_CAP    = DEF_TELEMETRY_DEPTH;
   localparam int STREAM_CAP  = DEF_PER_STREAM_DEPTH;
   localparam int AUDIO_CAP   = DEF_AUDIO_DEPTH;
   localparam int VIDEO_SLOTS = DEF_STREAM_COUNT * DEF_PER_STREAM_DEPTH;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [15:0] hdl;
      logic        ctl;
   } tele_pkt_type;

   typedef struct {
      logic [15:0] hdl;
      logic [1:0]  strm;
   } video_frame_type;

   typedef struct {
      logic [KIND_BITS-1:0] kind;
      logic [15:0]          hdl;
      logic                 ctl;
      logic [1:0]           strm;
      logic                 last;
   } dispatch_type;

   // one row of the directed table; known rows carry a hand-written expectation
   typedef struct {
      logic [OP_BITS-1:0] op;
      logic [15:0]        hdl;
      logic               ctl;
      logic [1:0]         strm;
      logic               key;
      bit                 known;
      int                 n_out;
      dispatch_type       first;
   } step_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_BITS-1:0]       req_operation = '0;
   logic [15:0]              req_handle = '0;
   logic                     req_is_control = 1'b0;
   logic [STREAM_BITS-1:0]   req_stream = '0;
   logic                     req_is_keyframe = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [KIND_BITS-1:0]     rsp_kind;
   logic [15:0]              rsp_out_handle;
   logic                     rsp_out_control;
   logic [STREAM_BITS-1:0]   rsp_out_stream;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   priority_drop_packet_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_handle(req_handle),
      .req_is_control(req_is_control), .req_stream(req_stream),
      .req_is_keyframe(req_is_keyframe),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_out_handle(rsp_out_handle),
      .rsp_out_control(rsp_out_control), .rsp_out_stream(rsp_out_stream),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // scheduler shadow state
   tele_pkt_type    tele_q[$];
   video_frame_type video_q[$];
   logic [15:0]     audio_q[$];
   bit              halted;
   logic [7:0]      tele_lim = TLIM_RESET;
   logic [1:0]      video_lim = VLIM_RESET;
   logic [5:0]      audio_lim = ALIM_RESET;

   dispatch_type pending_q[$];
   int           errors;
   int           cycles;
   int           n_items;
   int           n_checked;
   int           burst_left;
   int           hold_tokens;
   int           hold_seen;
   int           hold_left;
   int           stall_mode;

   function automatic int clamp_lim(int v, int cap);
      if (v == 0) return 1;
      return (v > cap) ? cap : v;
   endfunction

   // apply one item to the shadow state and queue the dispatched handles
   task automatic schedule_item(input logic [OP_BITS-1:0] op, input logic [15:0] hdl,
                                input logic ctl, input logic [1:0] strm, input logic key,
                                output int n_out, output dispatch_type first);
      int pos;
      int cnt;
      dispatch_type res[3];
      tele_pkt_type tp;
      video_frame_type vf;
      n_out = 0;
      first = '{default: '0};
      if (halted) return;
      case (op)
         OP_ENQ_TELEMETRY: begin
            if (tele_q.size() >= clamp_lim(tele_lim, TELE_CAP)) begin
               pos = 0;
               if (ctl) begin
                  foreach (tele_q[i]) begin
                     if (!tele_q[i].ctl) begin
                        pos = i;
                        break;
                     end
                  end
               end
               tele_q.delete(pos);
            end
            tp.hdl = hdl;
            tp.ctl = ctl;
            if (tele_q.size() < TELE_CAP) tele_q.insert(tele_q.size(), tp);
         end
         OP_ENQ_VIDEO: begin
            // keyframe purges the stream first
            if (key) begin
               for (int i = video_q.size() - 1; i >= 0; i--)
                  if (video_q[i].strm == strm) video_q.delete(i);
            end
            cnt = 0;
            foreach (video_q[i]) if (video_q[i].strm == strm) cnt++;
            if (cnt >= clamp_lim(video_lim, STREAM_CAP)) begin
               foreach (video_q[i]) begin
                  if (video_q[i].strm == strm) begin
                     video_q.delete(i);
                     break;
                  end
               end
            end
            vf.hdl = hdl;
            vf.strm = strm;
            if (video_q.size() < VIDEO_SLOTS) video_q.insert(video_q.size(), vf);
         end
         OP_ENQ_AUDIO: begin
            if (audio_q.size() >= clamp_lim(audio_lim, AUDIO_CAP)) audio_q.delete(0);
            if (audio_q.size() < AUDIO_CAP) audio_q.insert(audio_q.size(), hdl);
         end
         OP_DISPATCH: begin
            // first control packet, else the head
            if (tele_q.size() > 0) begin
               pos = 0;
               foreach (tele_q[i]) begin
                  if (tele_q[i].ctl) begin
                     pos = i;
                     break;
                  end
               end
               res[n_out++] = '{KIND_TELEMETRY, tele_q[pos].hdl, tele_q[pos].ctl, 2'd0, 1'b0};
               tele_q.delete(pos);
            end
            if (video_q.size() > 0) begin
               res[n_out++] = '{KIND_VIDEO, video_q[0].hdl, 1'b0, video_q[0].strm, 1'b0};
               video_q.delete(0);
            end
            if (audio_q.size() > 0) begin
               res[n_out++] = '{KIND_AUDIO, audio_q[0], 1'b0, 2'd0, 1'b0};
               audio_q.delete(0);
            end
            if (n_out > 0) res[n_out - 1].last = 1'b1;
            for (int i = 0; i < n_out; i++) pending_q.insert(pending_q.size(), res[i]);
            if (n_out > 0) first = res[0];
         end
         OP_STOP: begin
            halted = 1'b1;
            tele_q.delete();
            video_q.delete();
            audio_q.delete();
         end
         default: ;
      endcase
   endtask

   // offer one item and hold it until accepted, bursts and gaps around it
   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [15:0] hdl,
                            input logic ctl, input logic [1:0] strm, input logic key,
                            output int n_out, output dispatch_type first);
      req_valid <= 1'b1;
      req_operation <= op;
      req_handle <= hdl;
      req_is_control <= ctl;
      req_stream <= strm;
      req_is_keyframe <= key;
      do @(posedge clock); while (!req_ready);
      schedule_item(op, hdl, ctl, strm, key, n_out, first);
      n_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 8);
      end
   endtask

   task automatic random_item();
      int r;
      int n_out;
      dispatch_type first;
      logic [OP_BITS-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ENQ_TELEMETRY;
      else if (r < 55) op = OP_ENQ_VIDEO;
      else if (r < 73) op = OP_ENQ_AUDIO;
      else if (r < 97) op = OP_DISPATCH;
      else op = 3'($urandom_range(5, 7));
      send_item(op, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0), n_out, first);
   endtask

   // register write only once every dispatched handle has come back
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [7:0] val);
      wait (pending_q.size() == 0);
      repeat (12) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TELEMETRY_LIMIT:    tele_lim = val;
         CSR_VIDEO_STREAM_LIMIT: video_lim = val[1:0];
         CSR_AUDIO_LIMIT:        audio_lim = val[5:0];
         default: ;
      endcase
   endtask

   // receiver: long hold-off on request, otherwise its own stall pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_tokens) begin
         hold_seen <= hold_tokens;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= (cycles % 7) > 2;
         endcase
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected item: kind %0d handle %h", rsp_kind, rsp_out_handle);
            errors++;
         end else begin
            dispatch_type e;
            e = pending_q[0];
            pending_q.delete(0);
            n_checked++;
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d got %0d", e.kind, rsp_kind);
               errors++;
            end
            if (rsp_out_handle !== e.hdl) begin
               $error("out_handle: expected %h got %h", e.hdl, rsp_out_handle);
               errors++;
            end
            if (rsp_out_control !== e.ctl) begin
               $error("out_control: expected %0d got %0d", e.ctl, rsp_out_control);
               errors++;
            end
            if (rsp_out_stream !== e.strm) begin
               $error("out_stream: expected %0d got %0d", e.strm, rsp_out_stream);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // main sequence
   initial begin
      step_row_type steps[$];
      logic [7:0] tl_set[5];
      logic [7:0] vl_set[5];
      logic [7:0] al_set[5];
      int n_out;
      dispatch_type first;
      dispatch_type none;
      none = '{default: '0};
      tl_set = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd128};
      vl_set = '{8'd0, 8'd1, 8'd3, 8'd1, 8'd2};
      al_set = '{8'd0, 8'd1, 8'd63, 8'd5, 8'd32};

      // directed table at reset limits
      steps = '{
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 1, 0, none},
         '{OP_ENQ_TELEMETRY, 16'hFFFF, 0, 0, 0, 0, 0, none},
         '{OP_ENQ_TELEMETRY, 16'h0000, 1, 0, 0, 0, 0, none},
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 1, 1,
           '{KIND_TELEMETRY, 16'h0000, 1'b1, 2'd0, 1'b1}},
         '{OP_DISPATCH,      16'hFFFF, 1, 3, 1, 1, 1,
           '{KIND_TELEMETRY, 16'hFFFF, 1'b0, 2'd0, 1'b1}},
         '{OP_ENQ_VIDEO,     16'hFFFF, 0, 3, 0, 0, 0, none},
         '{OP_ENQ_VIDEO,     16'h1234, 0, 3, 0, 0, 0, none},
         '{OP_ENQ_VIDEO,     16'h5678, 0, 3, 0, 0, 0, none},
         '{OP_ENQ_VIDEO,     16'hAAAA, 0, 0, 1, 0, 0, none},
         '{OP_ENQ_VIDEO,     16'h0001, 1, 3, 1, 0, 0, none},
         '{OP_ENQ_AUDIO,     16'h0000, 0, 0, 0, 0, 0, none},
         '{OP_ENQ_AUDIO,     16'hFFFF, 1, 3, 1, 0, 0, none},
         '{OP_ENQ_TELEMETRY, 16'h8001, 1, 0, 0, 0, 0, none},
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 1, 3,
           '{KIND_TELEMETRY, 16'h8001, 1'b1, 2'd0, 1'b0}},
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 0, 0, none},
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 0, 0, none},
         '{3'd5,             16'hFFFF, 1, 3, 1, 0, 0, none},
         '{3'd6,             16'h5555, 0, 1, 0, 0, 0, none},
         '{3'd7,             16'hAAAA, 1, 2, 1, 0, 0, none},
         '{OP_DISPATCH,      16'h0000, 0, 0, 0, 1, 0, none}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         send_item(steps[i].op, steps[i].hdl, steps[i].ctl, steps[i].strm, steps[i].key,
                   n_out, first);
         if (steps[i].known) begin
            if (n_out != steps[i].n_out) begin
               $error("row %0d count: expected %0d got %0d", i, steps[i].n_out, n_out);
               errors++;
            end else if (n_out > 0 && first != steps[i].first) begin
               $error("row %0d first item: expected handle %h got %h", i,
                      steps[i].first.hdl, first.hdl);
               errors++;
            end
         end
      end

      // random phases, each under its own limits; queues carry over between phases
      for (int p = 0; p < 5; p++) begin
         req_valid <= 1'b0;
         write_reg(CSR_TELEMETRY_LIMIT, tl_set[p]);
         write_reg(CSR_VIDEO_STREAM_LIMIT, vl_set[p]);
         write_reg(CSR_AUDIO_LIMIT, al_set[p]);
         if (p == 2) begin
            // receiver holds off while the sender keeps offering
            hold_tokens++;
            burst_left = 40;
         end
         repeat (40) random_item();
      end

      // an audio enqueue, stop, then items that must have no effect
      send_item(OP_ENQ_AUDIO, 16'h00FF, 0, 0, 0, n_out, first);
      send_item(OP_STOP, 16'h0000, 0, 0, 0, n_out, first);
      send_item(OP_DISPATCH, 16'h0000, 0, 0, 0, n_out, first);
      send_item(OP_ENQ_TELEMETRY, 16'hBEEF, 1, 0, 0, n_out, first);
      send_item(OP_DISPATCH, 16'h0000, 0, 0, 0, n_out, first);
      send_item(OP_STOP, 16'h0000, 0, 0, 0, n_out, first);
      req_valid <= 1'b0;

      wait (pending_q.size() == 0);
      repeat (60) @(posedge clock);
      $display("run: %0d items sent, %0d dispatched handles checked, 5 limit settings",
               n_items, n_checked);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/pdps_pkg.sv
src/pdps_cell.sv
src/pdps_chain.sv
src/priority_drop_packet_scheduler.sv
bench/priority_drop_packet_scheduler_tb.sv
